### design/cfirlp_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cfirlp_pkg: shared definitions for the complex I/Q FIR filter
// Sizes, operation codes and the control word passed to the MAC datapath.
// ---------------------------------------------------------------------------
package cfirlp_pkg;

    localparam int MAX_TAPS     = 64;
    localparam int SAMPLE_WIDTH = 16;
    localparam int COEF_WIDTH   = 16;

    localparam int ADDR_W       = $clog2(MAX_TAPS);
    localparam int CNT_W        = $clog2(MAX_TAPS + 1);
    localparam int TAP_CFG_W    = 7;
    localparam int COEF_IDX_W   = 6;
    localparam int PROD_W       = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int ACC_W        = PROD_W + $clog2(MAX_TAPS);

    // Operation codes carried by an input word.
    localparam logic OP_FILTER = 1'b0;
    localparam logic OP_COEF   = 1'b1;

    // Control from the sequencer to the multiply-accumulate datapath.
    typedef struct packed {
        logic clear;       // zero both accumulators
        logic data_valid;  // memory read data holds one tap this cycle
    } t_mac_ctrl;

endpackage

### design/complex_fir_lowpass_filter.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// complex_fir_lowpass_filter: complex I/Q FIR filter, real coefficients
// Circular I/Q delay memory, coefficient memory and one shared dual MAC.
// ---------------------------------------------------------------------------
//
//  Channel | Direction | Handshake                 | Word
//  --------+-----------+---------------------------+---------------------------------
//  input   | in        | i_in_valid / o_in_stall   | operation, samples, coef index/value
//  output  | out       | o_out_valid / i_out_stall | filtered_i, filtered_q
//  config  | in        | i_cfg_valid / o_cfg_ready | tap_count (7 bits)
//
// A sample word occupies the block while it writes the sample, reads one tap
// at a time for each of the n taps in use (1 to 64) from the single read port
// of the delay and coefficient memories, drains the multiply and accumulate
// stages and rounds the result; n is the tap count in use.
// A coefficient word leaves the block idle and returns nothing.
// Reset is synchronous and active low; the valid bits of both memories clear at
// once, so the block accepts words in the first cycle after reset.
// A stalled result waits in the output register while the next word is taken.
// ---------------------------------------------------------------------------
module complex_fir_lowpass_filter (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    // Input word channel.
    input  logic                                       i_in_valid,
    output logic                                       o_in_stall,
    input  logic                                       i_operation,
    input  logic signed [cfirlp_pkg::SAMPLE_WIDTH-1:0] i_sample_i,
    input  logic signed [cfirlp_pkg::SAMPLE_WIDTH-1:0] i_sample_q,
    input  logic [cfirlp_pkg::COEF_IDX_W-1:0]          i_coef_index,
    input  logic signed [cfirlp_pkg::COEF_WIDTH-1:0]   i_coef_value,
    // Result word channel.
    output logic                                       o_out_valid,
    input  logic                                       i_out_stall,
    output logic signed [cfirlp_pkg::SAMPLE_WIDTH-1:0] o_filtered_i,
    output logic signed [cfirlp_pkg::SAMPLE_WIDTH-1:0] o_filtered_q,
    // Configuration write channel for tap_count.
    input  logic                                       i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  logic [cfirlp_pkg::TAP_CFG_W-1:0]           i_cfg_data
);

    localparam int SW = cfirlp_pkg::SAMPLE_WIDTH;
    localparam int AW = cfirlp_pkg::ADDR_W;
    localparam int CW = cfirlp_pkg::CNT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_FINISH
    } t_state;

    t_state                           r_state, n_state;
    logic [cfirlp_pkg::TAP_CFG_W-1:0] r_tap_count;
    logic [AW-1:0]                    r_wp, n_wp;
    logic [AW-1:0]                    r_rd_ptr, n_rd_ptr;
    logic [AW-1:0]                    r_k, n_k;
    logic [CW-1:0]                    r_n, n_n;
    logic                             r_drain, n_drain;
    logic                             r_data_valid;
    logic                             r_out_valid, n_out_valid;
    logic signed [SW-1:0]             r_out_i, r_out_q;

    logic                             in_accept;
    logic                             out_accept;
    logic                             out_load;
    logic [CW-1:0]                    taps_in_use;
    logic [AW-1:0]                    wp_use;
    logic [CW-1:0]                    wp_inc;
    logic                             dly_we;
    logic                             coef_we;
    logic [2*SW-1:0]                  dly_rd_data;
    logic [cfirlp_pkg::COEF_WIDTH-1:0] coef_rd_data;
    cfirlp_pkg::t_mac_ctrl            mac_ctrl;
    logic signed [SW-1:0]             mac_res_i, mac_res_q;

    // The block takes new words only while no sample is being filtered.
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_accept  = r_out_valid && !i_out_stall;
    assign out_load    = (r_state == S_FINISH) && (!r_out_valid || !i_out_stall);

    // A tap count of zero behaves as one; anything past the table behaves as
    // the full table.
    always_comb begin
        if (r_tap_count == '0) begin
            taps_in_use = CW'(1);
        end else if (int'(r_tap_count) > cfirlp_pkg::MAX_TAPS) begin
            taps_in_use = CW'(cfirlp_pkg::MAX_TAPS);
        end else begin
            taps_in_use = CW'(r_tap_count);
        end
    end

    // When the tap count has shrunk to or below the write position, the circular
    // buffer restarts at entry zero.
    assign wp_use  = (CW'(r_wp) >= taps_in_use) ? '0 : r_wp;
    assign wp_inc  = CW'(wp_use) + CW'(1);
    assign dly_we  = in_accept && (i_operation == cfirlp_pkg::OP_FILTER);
    assign coef_we = in_accept && (i_operation == cfirlp_pkg::OP_COEF)
                     && (int'(i_coef_index) < cfirlp_pkg::MAX_TAPS);

    // The sample is written in the accept cycle and the first tap read starts in
    // the next cycle, so a read never meets a write to the same entry.
    always_comb begin
        n_state     = r_state;
        n_wp        = r_wp;
        n_rd_ptr    = r_rd_ptr;
        n_k         = r_k;
        n_n         = r_n;
        n_drain     = r_drain;
        n_out_valid = r_out_valid;
        if (out_accept) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (dly_we) begin
                    n_wp     = (wp_inc == taps_in_use) ? '0 : AW'(wp_inc);
                    n_rd_ptr = wp_use;
                    n_k      = '0;
                    n_n      = taps_in_use;
                    n_state  = S_RUN;
                end
            end
            S_RUN: begin
                // Walk backward from the newest sample, wrapping at n.
                n_rd_ptr = (r_rd_ptr == '0) ? AW'(r_n - CW'(1)) : r_rd_ptr - AW'(1);
                n_k      = r_k + AW'(1);
                if (CW'(r_k) == r_n - CW'(1)) begin
                    n_drain = 1'b0;
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // Wait for the product register, then for the sum.
                n_drain = 1'b1;
                if (r_drain) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_tap_count  <= cfirlp_pkg::TAP_CFG_W'(cfirlp_pkg::MAX_TAPS);
            r_wp         <= '0;
            r_rd_ptr     <= '0;
            r_k          <= '0;
            r_n          <= '0;
            r_drain      <= 1'b0;
            r_data_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_wp         <= n_wp;
            r_rd_ptr     <= n_rd_ptr;
            r_k          <= n_k;
            r_n          <= n_n;
            r_drain      <= n_drain;
            r_data_valid <= (r_state == S_RUN);
            r_out_valid  <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_tap_count <= i_cfg_data;
            end
        end
        if (out_load) begin
            r_out_i <= mac_res_i;
            r_out_q <= mac_res_q;
        end
    end

    // I and Q share one delay memory word, I in the upper half.
    cfirlp_ram #(
        .WIDTH (2 * SW),
        .DEPTH (cfirlp_pkg::MAX_TAPS)
    ) u_delay_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (dly_we),
        .i_wr_addr (wp_use),
        .i_wr_data ({i_sample_i, i_sample_q}),
        .i_rd_addr (r_rd_ptr),
        .o_rd_data (dly_rd_data)
    );

    cfirlp_ram #(
        .WIDTH (cfirlp_pkg::COEF_WIDTH),
        .DEPTH (cfirlp_pkg::MAX_TAPS)
    ) u_coef_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (coef_we),
        .i_wr_addr (AW'(i_coef_index)),
        .i_wr_data (i_coef_value),
        .i_rd_addr (r_k),
        .o_rd_data (coef_rd_data)
    );

    assign mac_ctrl.clear      = dly_we;
    assign mac_ctrl.data_valid = r_data_valid;

    cfirlp_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (mac_ctrl),
        .i_data_i ($signed(dly_rd_data[2*SW-1:SW])),
        .i_data_q ($signed(dly_rd_data[SW-1:0])),
        .i_coef   ($signed(coef_rd_data)),
        .o_res_i  (mac_res_i),
        .o_res_q  (mac_res_q)
    );

    assign o_out_valid  = r_out_valid;
    assign o_filtered_i = r_out_i;
    assign o_filtered_q = r_out_q;

endmodule

### design/cfirlp_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cfirlp_ram: one-write one-read synchronous RAM with per-entry valid bits
// Read data is registered. An entry never written since reset reads as zero.
// ---------------------------------------------------------------------------
module cfirlp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [WIDTH-1:0] r_rd_data;
    logic             r_rd_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            r_rd_hit <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_hit ? r_rd_data : '0;

endmodule

### design/cfirlp_mac.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cfirlp_mac: dual real-coefficient multiply-accumulate with round/saturate
// One I and one Q product per tap, registered, then summed exactly.
// ---------------------------------------------------------------------------
module cfirlp_mac (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  cfirlp_pkg::t_mac_ctrl                    i_ctrl,
    input  logic signed [cfirlp_pkg::SAMPLE_WIDTH-1:0] i_data_i,
    input  logic signed [cfirlp_pkg::SAMPLE_WIDTH-1:0] i_data_q,
    input  logic signed [cfirlp_pkg::COEF_WIDTH-1:0]   i_coef,
    output logic signed [cfirlp_pkg::SAMPLE_WIDTH-1:0] o_res_i,
    output logic signed [cfirlp_pkg::SAMPLE_WIDTH-1:0] o_res_q
);

    localparam int SW = cfirlp_pkg::SAMPLE_WIDTH;
    localparam int FB = cfirlp_pkg::COEF_WIDTH - 1;
    localparam int RW = cfirlp_pkg::ACC_W + 1;
    localparam logic signed [RW-1:0] HALF   = {{(RW-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}};
    localparam logic signed [RW-1:0] SAT_HI = {{(RW-SW+1){1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [RW-1:0] SAT_LO = ~SAT_HI;

    logic signed [cfirlp_pkg::PROD_W-1:0] r_prod_i, r_prod_q;
    logic                                 r_prod_valid;
    logic signed [cfirlp_pkg::ACC_W-1:0]  r_acc_i, r_acc_q;

    // Add one half, floor-shift, then clamp to the sample range.
    function automatic logic signed [SW-1:0] round_sat(
        input logic signed [cfirlp_pkg::ACC_W-1:0] acc
    );
        logic signed [RW-1:0] sum;
        logic signed [RW-1:0] shifted;
        logic signed [SW-1:0] res;
        sum     = RW'(acc) + HALF;
        shifted = sum >>> FB;
        if (shifted > SAT_HI) begin
            res = SAT_HI[SW-1:0];
        end else if (shifted < SAT_LO) begin
            res = SAT_LO[SW-1:0];
        end else begin
            res = shifted[SW-1:0];
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        r_prod_i <= i_data_i * i_coef;
        r_prod_q <= i_data_q * i_coef;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
        end else begin
            r_prod_valid <= i_ctrl.data_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            r_acc_i <= '0;
            r_acc_q <= '0;
        end else if (r_prod_valid) begin
            r_acc_i <= r_acc_i + cfirlp_pkg::ACC_W'(r_prod_i);
            r_acc_q <= r_acc_q + cfirlp_pkg::ACC_W'(r_prod_q);
        end
    end

    assign o_res_i = round_sat(r_acc_i);
    assign o_res_q = round_sat(r_acc_q);

endmodule

### design/cfirlp_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cfirlp_checker: port-level checks for the complex I/Q FIR filter
// Watches the handshakes and the busy window around a filtered sample.
// ---------------------------------------------------------------------------
module cfirlp_checker (
    input logic                                       i_clk,
    input logic                                       i_rst_n,
    input logic                                       i_in_valid,
    input logic                                       o_in_stall,
    input logic                                       i_operation,
    input logic                                       o_out_valid,
    input logic                                       i_out_stall,
    input logic signed [cfirlp_pkg::SAMPLE_WIDTH-1:0] o_filtered_i,
    input logic signed [cfirlp_pkg::SAMPLE_WIDTH-1:0] o_filtered_q
);

    // Reset empties the output register.
    a_reset_clears_output: assert property (
        @(posedge i_clk) !i_rst_n |=> !o_out_valid
    ) else $error("result still valid after reset");

    // A waiting result holds its value.
    a_stalled_result_holds: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_filtered_i) && $stable(o_filtered_q)
    ) else $error("stalled result changed or vanished");

    // A coefficient word never makes the block busy.
    a_coef_word_no_busy: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_operation == cfirlp_pkg::OP_COEF) |=> !o_in_stall
    ) else $error("coefficient word stalled the input");

    // A sample word starts a filtering pass, and a new result only appears at
    // the end of such a pass.
    a_sample_starts_pass: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_operation == cfirlp_pkg::OP_FILTER) |=> o_in_stall
    ) else $error("sample word did not start a filtering pass");

    a_result_after_pass: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall)
    ) else $error("result appeared outside a filtering pass");

endmodule

bind complex_fir_lowpass_filter cfirlp_checker u_cfirlp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .i_operation  (i_operation),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_filtered_i (o_filtered_i),
    .o_filtered_q (o_filtered_q)
);
